>>> src/photo_sensor_position_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Photo-sensor position tracker assertion macros
// Shared concurrent assertion forms for the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef PHOTO_SENSOR_POSITION_TRACKER_UNIT_DEFINES_SVH
`define PHOTO_SENSOR_POSITION_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define PSPT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define PSPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pspt_pkg.sv
// ----------------------------------------------------------------------------
// Photo-sensor position tracker package
// Shared types, register map and reset constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pspt_pkg;

    localparam logic [15:0] PERIOD_RESET  = 16'd8;
    localparam logic [3:0]  CONFIRM_RESET = 4'd3;
    localparam logic [15:0] PULSE_RESET   = 16'd50;

    // Phase that stands for a count of one under the reset period
    localparam logic [15:0] PHASE_RESET = (PERIOD_RESET <= 16'd1) ? 16'd0 : 16'd1;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_PERIOD  = 2'd0,
        REG_CONFIRM = 2'd1,
        REG_PULSE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] count_period;
        logic [3:0]  confirm_limit;
        logic [15:0] pulse_length;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic        count_sensor;
        logic        reset_sensor;
        logic [31:0] interval_value;
        logic [31:0] speed_value;
        logic [15:0] servo_value;
    } item_t;

    typedef struct packed {
        logic        report_valid;
        logic [15:0] prev_car;
        logic [15:0] cur_car;
        logic [31:0] report_interval;
        logic [31:0] report_speed;
        logic [15:0] report_servo;
        logic        pulse_out;
        logic [15:0] edge_count;
    } result_t;

endpackage

>>> src/pspt_debounce.sv
// ----------------------------------------------------------------------------
// Sensor debouncer
// Confirms a new sensor level after it holds beyond the confirm limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspt_debounce
    import pspt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       raw,
    input  logic [3:0] limit,
    output logic       change
);

    logic       stable_reg, stable_next;
    logic       cand_reg, cand_next;
    logic [4:0] conf_reg, conf_next;
    logic       cand_mid;
    logic [4:0] conf_inc;

    always_comb
    begin
        // Load a fresh candidate only when no confirmation is running
        cand_mid    = (stable_reg != raw && conf_reg == 5'd0) ? raw : cand_reg;
        conf_inc    = conf_reg + 5'd1;
        stable_next = stable_reg;
        cand_next   = cand_mid;
        conf_next   = conf_reg;
        change      = 1'b0;
        if (en)
        begin
            if (cand_mid == raw && cand_mid != stable_reg)
            begin
                if (conf_inc > {1'b0, limit})
                begin
                    stable_next = cand_mid;
                    conf_next   = 5'd0;
                    change      = 1'b1;
                end
                else
                begin
                    conf_next = conf_inc;
                end
            end
            else
            begin
                cand_next = stable_reg;
                conf_next = 5'd0;
            end
        end
        else
        begin
            cand_next = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
            conf_reg   <= 5'd0;
        end
        else
        begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            conf_reg   <= conf_next;
        end
    end

endmodule

>>> src/pspt_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write and read of period, confirm limit and pulse length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspt_regs
    import pspt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_PERIOD:  cfg_next.count_period  = pwdata[15:0];
                REG_CONFIRM: cfg_next.confirm_limit = pwdata[3:0];
                REG_PULSE:   cfg_next.pulse_length  = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PERIOD:  prdata = {16'd0, cfg_reg.count_period};
            REG_CONFIRM: prdata = {28'd0, cfg_reg.confirm_limit};
            REG_PULSE:   prdata = {16'd0, cfg_reg.pulse_length};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_period  <= PERIOD_RESET;
            cfg_reg.confirm_limit <= CONFIRM_RESET;
            cfg_reg.pulse_length  <= PULSE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/pspt_tracker.sv
// ----------------------------------------------------------------------------
// Position tracker datapath
// Input register, count/period/pulse update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspt_tracker
    import pspt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic        in_vld_reg, in_vld_next;
    item_t       item_reg;
    logic        out_vld_reg, out_vld_next;
    result_t     res_reg, res_next;
    logic        adv;
    logic        take;
    logic        fire;
    logic        scan;
    logic        cnt_chg;
    logic        rst_chg;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] phase_reg, phase_next;
    logic [15:0] car_reg, car_next;
    logic [15:0] rem_reg, rem_next;
    logic        lvl_reg, lvl_next;
    logic [15:0] pos_inc;
    logic [16:0] phase_inc;
    logic [15:0] phase_adv;
    logic [15:0] rem_dec;
    logic [15:0] phase_one;

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || adv;
    assign take     = in_valid && in_ready;
    assign fire     = in_vld_reg && adv;
    assign scan     = fire && !item_reg.kind;

    assign out_valid = out_vld_reg;
    assign out_res   = res_reg;

    pspt_debounce u_cnt_deb (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (scan),
        .raw    (item_reg.count_sensor),
        .limit  (cfg.confirm_limit),
        .change (cnt_chg)
    );

    pspt_debounce u_rst_deb (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (scan),
        .raw    (item_reg.reset_sensor),
        .limit  (cfg.confirm_limit),
        .change (rst_chg)
    );

    always_comb
    begin
        pos_inc   = pos_reg + 16'd1;
        phase_inc = {1'b0, phase_reg} + 17'd1;
        // Wrap the phase at the period; a zero period behaves as one
        phase_adv = (phase_inc >= {1'b0, cfg.count_period}) ? 16'd0 : phase_inc[15:0];
        rem_dec   = rem_reg - 16'd1;
        phase_one = (cfg.count_period <= 16'd1) ? 16'd0 : 16'd1;

        pos_next   = pos_reg;
        phase_next = phase_reg;
        car_next   = car_reg;
        rem_next   = rem_reg;
        lvl_next   = lvl_reg;
        res_next   = '0;

        if (fire && item_reg.kind)
        begin
            if (rem_reg != 16'd0)
            begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    lvl_next = 1'b0;
                end
            end
        end
        else if (scan)
        begin
            if (cnt_chg)
            begin
                pos_next   = pos_inc;
                phase_next = phase_adv;
                if (pos_inc != 16'd0 && phase_adv == 16'd0)
                begin
                    rem_next                 = cfg.pulse_length;
                    lvl_next                 = (cfg.pulse_length != 16'd0);
                    car_next                 = car_reg + 16'd1;
                    res_next.report_valid    = 1'b1;
                    res_next.prev_car        = car_reg;
                    res_next.cur_car         = car_reg + 16'd1;
                    res_next.report_interval = item_reg.interval_value;
                    res_next.report_speed    = item_reg.speed_value;
                    res_next.report_servo    = item_reg.servo_value;
                end
            end
            // Reset channel acts after the count channel
            if (rst_chg)
            begin
                pos_next   = 16'd0;
                car_next   = 16'd0;
                phase_next = phase_one;
            end
        end

        res_next.pulse_out  = lvl_next;
        res_next.edge_count = pos_next;

        in_vld_next  = take ? 1'b1 : (adv ? 1'b0 : in_vld_reg);
        out_vld_next = adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pos_reg     <= 16'd0;
            phase_reg   <= PHASE_RESET;
            car_reg     <= 16'd0;
            rem_reg     <= 16'd0;
            lvl_reg     <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            car_reg     <= car_next;
            rem_reg     <= rem_next;
            lvl_reg     <= lvl_next;
        end
    end

    // Payload registers: hold unless a transfer moves them on
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> src/photo_sensor_position_tracker_unit.sv
// ----------------------------------------------------------------------------
// Photo-sensor position tracker
// Debounced edge counter with periodic car reports and an output pulse.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is ready and
// returns exactly one result per item via the input register, then a single
// update of debouncers, count, period phase and pulse timer into the result
// register. A stalled output holds both stages; the input side keeps accepting
// until they are full. The user must see that configuration is written over
// the APB port only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module photo_sensor_position_tracker_unit
    import pspt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] count_sensor, [1] reset_sensor, [33:2] interval_value,
    // [65:34] speed_value, [81:66] servo_value, [87:82] zero
    input  logic [87:0]       s_axis_tdata,
    // [0] kind
    input  logic              s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] prev_car, [31:16] cur_car, [63:32] report_interval,
    // [95:64] report_speed, [111:96] report_servo, [112] pulse_out,
    // [128:113] edge_count, [135:129] zero
    output logic [135:0]      m_axis_tdata,
    // [0] report_valid
    output logic              m_axis_tuser
);

    cfg_t    cfg;
    item_t   item;
    result_t res;

    pspt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        item.kind           = s_axis_tuser;
        item.count_sensor   = s_axis_tdata[0];
        item.reset_sensor   = s_axis_tdata[1];
        item.interval_value = s_axis_tdata[33:2];
        item.speed_value    = s_axis_tdata[65:34];
        item.servo_value    = s_axis_tdata[81:66];
    end

    pspt_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tuser = res.report_valid;
    assign m_axis_tdata = {7'd0, res.edge_count, res.pulse_out, res.report_servo,
                           res.report_speed, res.report_interval, res.cur_car,
                           res.prev_car};

endmodule

>>> src/pspt_checker.sv
// ----------------------------------------------------------------------------
// Photo-sensor position tracker checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "photo_sensor_position_tracker_unit_defines.svh"

module pspt_checker
    import pspt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    `PSPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `PSPT_ASSERT_NOW(a_car_step, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:16] == m_axis_tdata[15:0] + 16'd1, "car number did not advance by one")

    `PSPT_ASSERT_NOW(a_quiet_fields, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[111:0] == 112'd0, "report fields set without a report")

endmodule

bind photo_sensor_position_tracker_unit pspt_checker u_pspt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
